// File: rtl/core/cimf_pkg.sv
// Shared types and constants for the CAN identifier/mask subscriber table.
`timescale 1ns / 1ps
`default_nettype none

package cimf_pkg;

    // Field widths
    localparam int ID_W     = 29;
    localparam int OWNER_W  = 8;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 24;

    // Operation codes
    typedef enum logic [1:0] {
        OP_MATCH        = 2'd0,
        OP_REGISTER     = 2'd1,
        OP_UNREG_OWNER  = 2'd2,
        OP_UNREG_FILTER = 2'd3
    } op_t;

    // Register result codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2
    } reg_status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // One stored table entry
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    mask;
    } entry_t;

    // Compare flags from the shared compare unit
    typedef struct packed {
        logic owner_eq;
        logic triple_eq;
        logic frame_hit;
        logic filter_hit;
    } cmp_t;

endpackage

`default_nettype wire

// File: rtl/core/cimf_cmp.sv
// Shared compare unit: checks one table entry against the latched key.
`timescale 1ns / 1ps
`default_nettype none

module cimf_cmp (
    input  wire cimf_pkg::entry_t                  entry_i,
    input  wire logic [cimf_pkg::OWNER_W-1:0]      key_owner_i,
    input  wire logic [cimf_pkg::ID_W-1:0]         key_id_i,
    input  wire logic [cimf_pkg::ID_W-1:0]         key_mask_i,
    output cimf_pkg::cmp_t                         cmp_o
);
    import cimf_pkg::*;

    logic [ID_W-1:0] id_diff;
    logic            mask_eq;

    assign id_diff = key_id_i ^ entry_i.id;
    assign mask_eq = (key_mask_i == entry_i.mask);

    // Frame match uses the entry mask; filter removal uses the key mask
    always_comb begin
        cmp_o.owner_eq   = (key_owner_i == entry_i.owner);
        cmp_o.triple_eq  = cmp_o.owner_eq && mask_eq && (id_diff == '0);
        cmp_o.frame_hit  = ((id_diff & entry_i.mask) == '0);
        cmp_o.filter_hit = cmp_o.owner_eq && mask_eq && ((id_diff & key_mask_i) == '0);
    end

endmodule

`default_nettype wire

// File: rtl/core/can_id_mask_filter_table.sv
// Steps: accept the item, scan the table slots in order, then the final transfer.
// A new item is accepted only once the previous one has finished (s_tready in idle);
//   a register op that finds its triple already present ends the scan at that slot.
// A match emits extra hits during the scan, each as the next hit is found.
// Reset (aresetn low, synchronous): table empty, sequencer idle, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module can_id_mask_filter_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: frame_id[28:0], owner_handle[36:29], filter_id[65:37], filter_mask[94:66]
    input  wire logic [cimf_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: op[1:0]
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: slot_index[5:0], matched_owner[13:6], removed_count[20:14], status[22:21]
    output logic [cimf_pkg::M_DATA_W-1:0]       m_tdata,
    // m_tuser: hit[0]
    output logic                                m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import cimf_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Sequencer and latched item
    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [OWNER_W-1:0]  key_owner_reg, key_owner_next;
    logic [ID_W-1:0]     key_id_reg, key_id_next;
    logic [ID_W-1:0]     key_mask_reg, key_mask_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    // Held hit (pending match result or duplicate found)
    logic                hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0]    hold_slot_reg, hold_slot_next;
    logic [OWNER_W-1:0]  hold_owner_reg, hold_owner_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_slot_reg, free_slot_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_hit_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [OWNER_W-1:0]  out_owner_reg, out_owner_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;
    logic                out_load;

    // Table memory
    entry_t              mem [TABLE_DEPTH];
    entry_t              rd_entry_reg;
    logic                mem_we;
    cmp_t                cmp;

    // Scan helpers
    logic entry_valid;
    logic out_free;
    logic last_slot;
    logic dup_hit;
    logic scan_stall;

    assign s_tready    = (state_reg == S_IDLE);
    assign entry_valid = valid_reg[idx_reg];
    assign out_free    = !out_valid_reg || m_tready;
    assign last_slot   = (idx_reg == LAST_IDX);
    assign dup_hit     = (op_reg == OP_REGISTER) && entry_valid && cmp.triple_eq;
    assign scan_stall  = (op_reg == OP_MATCH) && entry_valid && cmp.frame_hit
                         && hold_valid_reg && !out_free;

    cimf_cmp u_cmp (
        .entry_i     (rd_entry_reg),
        .key_owner_i (key_owner_reg),
        .key_id_i    (key_id_reg),
        .key_mask_i  (key_mask_reg),
        .cmp_o       (cmp)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (dup_hit || (!scan_stall && last_slot)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        op_next         = op_reg;
        key_owner_next  = key_owner_reg;
        key_id_next     = key_id_reg;
        key_mask_next   = key_mask_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_owner_next = hold_owner_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        out_load        = 1'b0;
        out_hit_next    = 1'b0;
        out_slot_next   = '0;
        out_owner_next  = '0;
        out_count_next  = '0;
        out_status_next = ST_INSERTED;
        out_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = op_t'(s_tuser);
                    key_owner_next  = s_tdata[36:29];
                    key_id_next     = (op_t'(s_tuser) == OP_MATCH) ? s_tdata[28:0]
                                                                   : s_tdata[65:37];
                    key_mask_next   = s_tdata[94:66];
                    idx_next        = '0;
                    hold_valid_next = 1'b0;
                    free_found_next = 1'b0;
                    count_next      = '0;
                end
            end
            S_SCAN: begin
                unique case (op_reg)
                    OP_MATCH: begin
                        if (entry_valid && cmp.frame_hit && !scan_stall) begin
                            // Earlier hit goes out now; it is not the last one
                            if (hold_valid_reg) begin
                                out_load       = 1'b1;
                                out_hit_next   = 1'b1;
                                out_slot_next  = SLOT_W'(hold_slot_reg);
                                out_owner_next = hold_owner_reg;
                                out_last_next  = 1'b0;
                            end
                            hold_valid_next = 1'b1;
                            hold_slot_next  = idx_reg;
                            hold_owner_next = rd_entry_reg.owner;
                        end
                    end
                    OP_REGISTER: begin
                        if (dup_hit) begin
                            hold_valid_next = 1'b1;
                            hold_slot_next  = idx_reg;
                        end else if (!entry_valid && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_slot_next  = idx_reg;
                        end
                    end
                    OP_UNREG_OWNER: begin
                        if (entry_valid && cmp.owner_eq) begin
                            valid_next[idx_reg] = 1'b0;
                            count_next          = count_reg + COUNT_W'(1);
                        end
                    end
                    OP_UNREG_FILTER: begin
                        if (entry_valid && cmp.filter_hit) begin
                            valid_next[idx_reg] = 1'b0;
                            count_next          = count_reg + COUNT_W'(1);
                        end
                    end
                    default: ;
                endcase
                if (!scan_stall && !last_slot) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    unique case (op_reg)
                        OP_MATCH: begin
                            if (hold_valid_reg) begin
                                out_hit_next   = 1'b1;
                                out_slot_next  = SLOT_W'(hold_slot_reg);
                                out_owner_next = hold_owner_reg;
                            end
                        end
                        OP_REGISTER: begin
                            if (hold_valid_reg) begin
                                out_status_next = ST_PRESENT;
                                out_slot_next   = SLOT_W'(hold_slot_reg);
                                out_owner_next  = key_owner_reg;
                            end else if (free_found_reg) begin
                                out_status_next           = ST_INSERTED;
                                out_slot_next             = SLOT_W'(free_slot_reg);
                                out_owner_next            = key_owner_reg;
                                mem_we                    = 1'b1;
                                valid_next[free_slot_reg] = 1'b1;
                            end else begin
                                out_status_next = ST_FULL;
                            end
                        end
                        OP_UNREG_OWNER, OP_UNREG_FILTER: begin
                            out_count_next = count_reg;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Output valid: set on load, cleared once the transfer completes
    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_owner_reg  <= key_owner_next;
        key_id_reg     <= key_id_next;
        key_mask_reg   <= key_mask_next;
        idx_reg        <= idx_next;
        hold_valid_reg <= hold_valid_next;
        hold_slot_reg  <= hold_slot_next;
        hold_owner_reg <= hold_owner_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        count_reg      <= count_next;
        if (out_load) begin
            out_hit_reg    <= out_hit_next;
            out_slot_reg   <= out_slot_next;
            out_owner_reg  <= out_owner_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Table memory: one write port, registered read at the next scan slot
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[free_slot_reg] <= '{owner: key_owner_reg, id: key_id_reg, mask: key_mask_reg};
        end
        rd_entry_reg <= mem[idx_next];
    end

    // Result channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_count_reg, out_owner_reg, out_slot_reg};

endmodule

`default_nettype wire
